@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the LMS noise canceller.
// Stand-alone header; the assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held low.
`define LNC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs through reset.
`define LNC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LNC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LNC_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/lnc_pkg.sv @@
// Package for the LMS noise canceller: fixed widths, sequencer states, cell control.
// No dependencies.
`default_nettype none
package lnc_pkg;

  localparam int SMP_W  = 16;   // sample and error width
  localparam int W_W    = 48;   // weight width, Q16.32
  localparam int PROD_W = W_W + SMP_W;
  localparam int FRAC_W = 16;   // bits dropped from each tap product
  localparam int MU_W   = 6;
  localparam int SH_W   = 5;    // update shift, 0..31
  localparam logic [MU_W-1:0] MU_RESET = 6'd40;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_ERR,
    S_UPD_MUL,
    S_UPD_WR,
    S_OUT
  } lnc_state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     x_shift;    // new noise sample enters the delay line
    logic                     mac_load;   // load floored w*x
    logic                     term_shift; // pass terms along towards the accumulator
    logic                     upd_load;   // load e*x
    logic                     w_write;    // apply the weight update
    logic signed [SMP_W-1:0]  err;
    logic        [SH_W-1:0]   shift;
  } lnc_cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/lnc_cell.sv @@
// One tap of the LMS filter: delay element, weight, one multiplier and a term register.
// Depends on lnc_pkg.
`default_nettype none
module lnc_cell (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire lnc_pkg::lnc_cell_ctrl_t    ctrl,
  input  wire logic signed [15:0]         x_in,
  output logic signed [15:0]              x_out,
  input  wire logic signed [47:0]         term_in,
  output logic signed [47:0]              term_out
);
  import lnc_pkg::*;

  logic signed [SMP_W-1:0]  x_r,    x_nxt;
  logic signed [W_W-1:0]    w_r,    w_nxt;
  logic signed [W_W-1:0]    term_r, term_nxt;
  logic signed [W_W-1:0]    mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [W_W-1:0]    delta;
  logic signed [W_W:0]      w_sum;

  // one multiplier, shared by the filter pass and the update pass
  assign mul_a = ctrl.upd_load ? W_W'(ctrl.err) : w_r;
  assign prod  = mul_a * x_r;
  assign delta = term_r >>> ctrl.shift;
  assign w_sum = {w_r[W_W-1], w_r} + {delta[W_W-1], delta};

  always_comb begin
    x_nxt    = ctrl.x_shift ? x_in : x_r;
    term_nxt = term_r;
    if (ctrl.mac_load) begin
      term_nxt = prod[PROD_W-1:FRAC_W];
    end else if (ctrl.term_shift) begin
      term_nxt = term_in;
    end else if (ctrl.upd_load) begin
      term_nxt = prod[W_W-1:0];   // e*x fits in 32 bits
    end
    w_nxt = w_r;
    if (ctrl.w_write) begin
      if (w_sum[W_W] != w_sum[W_W-1]) begin
        w_nxt = w_sum[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
      end else begin
        w_nxt = w_sum[W_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      w_r <= '0;
    end else begin
      x_r <= x_nxt;
      w_r <= w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  assign x_out    = x_r;
  assign term_out = term_r;

endmodule
`default_nettype wire

@@ rtl/lms_noise_canceller.sv @@
// Top level of the LMS noise canceller: sequencer, accumulator, error path, ports.
// Depends on lnc_pkg, lnc_cell and assert_macros.svh.
`default_nettype none
// Adaptive LMS noise canceller. Each input word carries a desired sample
// (in_tdata[15:0]) and a noise reference sample (in_tdata[31:16]); each
// output word carries one error sample, e = d + n - y, saturated to 16 bits,
// where y is the FIR output of TAP_COUNT adaptive Q16.32 weights over the
// noise delay line (newest sample in tap 0). After the error is formed every
// weight moves by e * x[i] * 2^-mu_shift, saturated to 48 bits. The step is
// set through the cfg port (6 bits, reset 40; values below 32 act as 32) and
// should only be written while the block is idle. Each item runs through a
// product step, a sum pass that drains the products of the cell chain into
// the single accumulator, then error, update and output-load steps; no new
// input word is taken before the item is done. The next input word is
// accepted while the previous result is still waiting on out_tready; the
// result stage stalls only when a second result is ready before the first
// is taken. Weights and delay line clear on reset.
`include "assert_macros.svh"
module lms_noise_canceller #(
  parameter int TAP_COUNT = 30
) (
  input  wire               clk,
  input  wire               rst_n,
  // input stream
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [31:0]       in_tdata,   // [15:0] desired_sample, [31:16] noise_sample
  // result stream
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [15:0]       out_tdata,  // [15:0] error_sample
  // step register
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [5:0]        cfg_data    // mu_shift
);
  import lnc_pkg::*;

  localparam int CNT_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int ACC_W  = W_W + CNT_W + 1;
  localparam int FULL_W = ACC_W + 2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAP_COUNT - 1);

  lnc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [SMP_W:0]    dn_r,  dn_nxt;     // d + n
  logic signed [SMP_W-1:0]  err_r, err_nxt;
  logic [MU_W-1:0]          mu_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]         out_data_r,  out_data_nxt;

  logic                     in_acc;
  logic                     out_free;
  lnc_cell_ctrl_t           ctrl;

  logic signed [SMP_W-1:0]  d_smp, n_smp;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] e_full;
  logic [FULL_W-SMP_W:0]    e_upper;
  logic signed [SMP_W-1:0]  e_sat;

  // chain wiring: x flows from tap 0 upwards, terms flow to the last cell
  logic signed [SMP_W-1:0]  x_link    [TAP_COUNT+1];
  logic signed [W_W-1:0]    term_link [TAP_COUNT+1];

  assign d_smp  = in_tdata[15:0];
  assign n_smp  = in_tdata[31:16];
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign x_link[0]    = n_smp;
  assign term_link[0] = '0;

  for (genvar g = 0; g < TAP_COUNT; g++) begin : g_tap
    lnc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .x_in     (x_link[g]),
      .x_out    (x_link[g+1]),
      .term_in  (term_link[g]),
      .term_out (term_link[g+1])
    );
  end

  // error: floor(((d + n) << 16 - y) / 2^16), saturated to 16 bits
  assign full    = (FULL_W'(dn_r) <<< FRAC_W) - FULL_W'(acc_r);
  assign e_full  = full >>> FRAC_W;
  assign e_upper = e_full[FULL_W-1:15];
  always_comb begin
    if ((&e_upper) || !(|e_upper)) begin
      e_sat = e_full[SMP_W-1:0];
    end else begin
      e_sat = e_full[FULL_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    dn_nxt        = dn_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;

    ctrl.x_shift    = 1'b0;
    ctrl.mac_load   = 1'b0;
    ctrl.term_shift = 1'b0;
    ctrl.upd_load   = 1'b0;
    ctrl.w_write    = 1'b0;
    ctrl.err        = err_r;
    ctrl.shift      = mu_r[MU_W-1] ? mu_r[SH_W-1:0] : '0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.x_shift = 1'b1;
          dn_nxt       = (SMP_W+1)'(d_smp) + (SMP_W+1)'(n_smp);
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        ctrl.mac_load = 1'b1;
        acc_nxt       = '0;
        cnt_nxt       = '0;
        state_nxt     = S_SUM;
      end
      S_SUM: begin
        // last cell's term goes into the accumulator as the chain shifts
        ctrl.term_shift = 1'b1;
        acc_nxt         = acc_r + ACC_W'(term_link[TAP_COUNT]);
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        err_nxt   = e_sat;
        state_nxt = S_UPD_MUL;
      end
      S_UPD_MUL: begin
        ctrl.upd_load = 1'b1;
        state_nxt     = S_UPD_WR;
      end
      S_UPD_WR: begin
        ctrl.w_write = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mu_r        <= MU_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mu_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    dn_r       <= dn_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `LNC_ASSERT(a_accept_starts, clk, rst_n, in_acc |=> state_r == S_MUL, "accept did not start an item")
  `LNC_ASSERT(a_sum_length, clk, rst_n, (state_r == S_SUM && cnt_r == CNT_LAST) |=> state_r == S_ERR, "sum pass length wrong")
  `LNC_ASSERT(a_out_source, clk, rst_n, $rose(out_tvalid) |-> $past(state_r) == S_OUT, "result word without finished item")
  `LNC_ASSERT_RST(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !out_tvalid), "reset did not clear sequencer")

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking bench for lms_noise_canceller: stream drivers, result monitor, error predictor.
// Depends on lnc_pkg and the RTL of the canceller.
`timescale 1ns / 100ps
module tb;
  import lnc_pkg::*;

  localparam int TAP_COUNT  = 30;
  localparam int SETTLE     = TAP_COUNT + 12;   // settling wait used after a drain
  localparam int CYCLE_CAP  = 1_500_000;
  localparam int PHASE_LEN  = 157;
  localparam int NUM_PHASES = 7;

  // Tracks the canceller's weights and delay line, and queues the error
  // sample each accepted word should produce.
  class error_predictor;
    logic signed [W_W-1:0]   weights [TAP_COUNT];
    logic signed [SMP_W-1:0] history [TAP_COUNT];
    logic        [MU_W-1:0]  step_reg;
    logic signed [SMP_W-1:0] expected_errors [$];
    int                      mismatches;

    function new();
      foreach (weights[i]) begin
        weights[i] = '0;
        history[i] = '0;
      end
      step_reg   = MU_RESET;
      mismatches = 0;
    endfunction

    function void set_step(logic [MU_W-1:0] mu);
      step_reg = mu;
    endfunction

    function int pending();
      return expected_errors.size();
    endfunction

    function void take_sample(logic signed [SMP_W-1:0] d, logic signed [SMP_W-1:0] n);
      longint      fir_sum;
      longint      full_err;
      longint      err;
      longint      delta;
      longint      w;
      int unsigned sh;
      for (int i = TAP_COUNT - 1; i > 0; i--)
        history[i] = history[i-1];
      history[0] = n;
      fir_sum = 0;
      // each product is exact, then floored to Q.16 before it is summed
      for (int i = 0; i < TAP_COUNT; i++)
        fir_sum += (longint'(weights[i]) * longint'(history[i])) >>> 16;
      full_err = (longint'(d) + longint'(n)) * 65536 - fir_sum;
      err = full_err >>> 16;
      if (err > 32767)  err = 32767;
      if (err < -32768) err = -32768;
      // step register below 32 behaves as 32
      sh = ((step_reg < 32) ? 32 : int'(step_reg)) - 32;
      for (int i = 0; i < TAP_COUNT; i++) begin
        delta = (err * longint'(history[i])) >>> sh;
        w = longint'(weights[i]) + delta;
        if (w > 64'sh0000_7FFF_FFFF_FFFF)  w = 64'sh0000_7FFF_FFFF_FFFF;
        if (w < -64'sh0000_8000_0000_0000) w = -64'sh0000_8000_0000_0000;
        weights[i] = w[W_W-1:0];
      end
      expected_errors.push_back(err[SMP_W-1:0]);
    endfunction

    function void check_error(logic signed [SMP_W-1:0] got);
      logic signed [SMP_W-1:0] want;
      if (expected_errors.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected error word, expected none actual %0d", $time, got);
        return;
      end
      want = expected_errors.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: error_sample mismatch, expected %0d actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [31:0]     in_tdata   = '0;   // [15:0] desired_sample, [31:16] noise_sample
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [15:0]     out_tdata;         // [15:0] error_sample
  logic            cfg_valid  = 1'b0;
  logic            cfg_ready;
  logic [MU_W-1:0] cfg_data   = '0;   // mu_shift

  bit  calm = 1'b0;                   // no idling on either side while set
  int  cycles = 0;
  error_predictor predictor = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lms_noise_canceller #(.TAP_COUNT(TAP_COUNT)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // monitors: words are taken as they stood at the edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      predictor.take_sample(in_tdata[15:0], in_tdata[31:16]);
    if (rst_n && out_tvalid && out_tready)
      predictor.check_error(out_tdata);
  end

  // receiver back-pressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin : ready_gen
    int stall_left;
    int r;
    if (calm) begin
      out_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready <= 1'b1;
      end else if (r < 92) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(10, 80);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // mostly full range, some extremes, some quiet samples
  function automatic logic signed [SMP_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(0, 16'hFFFF));
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return $signed(16'($urandom_range(0, 511))) - 16'sd256;
  endfunction

  task automatic send_word(logic signed [SMP_W-1:0] d, logic signed [SMP_W-1:0] n);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {n, d};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and let every outstanding error word come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  task automatic write_step(logic [MU_W-1:0] mu);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mu;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    predictor.set_step(mu);
  endtask

  initial begin : stimulus
    logic signed [SMP_W-1:0] dir_d [16];
    logic signed [SMP_W-1:0] dir_n [16];
    logic        [MU_W-1:0]  phase_mu [NUM_PHASES];

    dir_d = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'shFFFF,
              16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh0000, 16'sh8000,
              16'sh4000, 16'shC000, 16'sh0000, 16'sh7FFF};
    dir_n = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'shFFFF,
              16'sh0001, 16'shAAAA, 16'sh5555, 16'sh0000, 16'sh8000, 16'sh0001,
              16'sh7FFF, 16'sh7FFF, 16'shFFFF, 16'sh7FFF};
    // fastest step, slowest step, below range, edge of range, mid values, random
    phase_mu = '{6'd32, 6'd63, 6'd0, 6'd31, 6'd47, 6'd36, 6'($urandom_range(32, 63))};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset step value
    foreach (dir_d[i]) send_word(dir_d[i], dir_n[i]);

    // directed extremes again with the largest step, where the weights run away
    write_step(6'd32);
    for (int i = 0; i < 8; i++) send_word(16'sh7FFF, (i[0]) ? 16'sh8000 : 16'sh7FFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_step(phase_mu[p]);
      calm = (p == 3);
      for (int k = 0; k < PHASE_LEN; k++) begin
        // one hold-off mid-phase until the block has caught up
        if (p == 1 && k == PHASE_LEN / 2) drain();
        send_word(pick_sample(), pick_sample());
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lnc_pkg.sv
rtl/lnc_cell.sv
rtl/lms_noise_canceller.sv
verif/tb.sv
